>>> sv/mdd_pkg.sv
// shared types, constants and round tables for the md5 message digest block
// no dependencies; used by mdd_front, mdd_back and md5_message_digest
package mdd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } out_item_t;

  // handoff from the input queue to the compression engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } q_head_t;

  // engine status, watched by the top-level checks
  typedef struct packed {
    logic       compressing;
    logic [5:0] round;
    logic       finishing;
  } bk_status_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [6:0]  LEN_POS = 7'd56;
  localparam logic [6:0]  BLK_END = 7'd64;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [1:0] q, input logic [1:0] j);
    logic [4:0] s;
    case ({q, j})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/mdd_front.sv
// input queue of the md5 block: holds accepted message bytes for the engine
// depends on mdd_pkg
module mdd_front #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mdd_pkg::in_item_t data,
  output mdd_pkg::q_head_t  head,
  input  logic              q_pop
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mdd_pkg::in_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = q_pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= data;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

>>> sv/mdd_back.sv
// compression engine of the md5 block: byte packing, padding, 64 rounds
// depends on mdd_pkg
module mdd_back (
  input  logic                clk,
  input  logic                rst,
  input  mdd_pkg::q_head_t    head,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output mdd_pkg::out_item_t  result,
  output mdd_pkg::bk_status_t status
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD0, S_PADZ, S_CLOAD, S_ROUND, S_CADD
  } state_t;

  typedef enum logic [1:0] {
    ACT_IDLE, ACT_PAD0, ACT_PADZ, ACT_FINAL
  } act_t;

  state_t      state;
  act_t        act;
  logic [31:0] words [16];
  logic [63:0] byte_total;
  logic [6:0]  pad_pos;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  round;
  logic        out_valid;

  logic [1:0]  quarter;
  logic [3:0]  i4;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] tt;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_val;
  logic [63:0] bit_len;

  assign q_pop = (state == S_IDLE) && head.valid;
  assign empty = !out_valid;
  assign status.compressing = (state == S_ROUND);
  assign status.round       = round;
  assign status.finishing   = (state == S_CADD) && (act == ACT_FINAL);

  assign quarter = round[5:4];
  assign i4      = round[3:0];

  always_comb begin
    case (quarter)
      2'd0: begin
        f = (wb & wc) | (~wb & wd);
        g = i4;
      end
      2'd1: begin
        f = (wb & wd) | (wc & ~wd);
        g = 4'(i4 * 4'd5 + 4'd1);
      end
      2'd2: begin
        f = wb ^ wc ^ wd;
        g = 4'(i4 * 4'd3 + 4'd5);
      end
      default: begin
        f = wc ^ (wb | ~wd);
        g = 4'(i4 * 4'd7);
      end
    endcase
  end

  assign t  = wa + f + mdd_pkg::sine_k(round) + words[g];
  assign tt = {t, t} << mdd_pkg::rot_amt(quarter, round[1:0]);

  assign sum_a = chain_a + wa;
  assign sum_b = chain_b + wb;
  assign sum_c = chain_c + wc;
  assign sum_d = chain_d + wd;
  assign bit_len = {byte_total[60:0], 3'b000};

  // byte lane written this cycle: message byte, pad marker or zero fill
  always_comb begin
    case (state)
      S_PAD0:  begin wr_pos = byte_total[5:0]; wr_val = mdd_pkg::PAD_BYTE;   end
      S_PADZ:  begin wr_pos = pad_pos[5:0];    wr_val = 8'h00;               end
      default: begin wr_pos = byte_total[5:0]; wr_val = head.item.data_byte; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      act        <= ACT_IDLE;
      byte_total <= '0;
      chain_a    <= mdd_pkg::INIT_A;
      chain_b    <= mdd_pkg::INIT_B;
      chain_c    <= mdd_pkg::INIT_C;
      chain_d    <= mdd_pkg::INIT_D;
      round      <= '0;
      out_valid  <= 1'b0;
      pad_pos    <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            if (head.item.has_byte) begin
              if (wr_pos[1:0] == 2'd0) begin
                words[wr_pos[5:2]] <= {24'h0, wr_val};
              end else begin
                words[wr_pos[5:2]] <= words[wr_pos[5:2]]
                                      | ({24'h0, wr_val} << {wr_pos[1:0], 3'b000});
              end
              byte_total <= byte_total + 64'd1;
              if (byte_total[5:0] == 6'd63) begin
                state <= S_CLOAD;
                act   <= head.item.last_byte ? ACT_PAD0 : ACT_IDLE;
              end else if (head.item.last_byte) begin
                state <= S_PAD0;
              end
            end else if (head.item.last_byte) begin
              state <= S_PAD0;
            end
          end
        end
        S_PAD0: begin
          if (wr_pos[1:0] == 2'd0) begin
            words[wr_pos[5:2]] <= {24'h0, wr_val};
          end else begin
            words[wr_pos[5:2]] <= words[wr_pos[5:2]]
                                  | ({24'h0, wr_val} << {wr_pos[1:0], 3'b000});
          end
          pad_pos <= {1'b0, byte_total[5:0]} + 7'd1;
          state   <= S_PADZ;
        end
        S_PADZ: begin
          if (pad_pos == mdd_pkg::LEN_POS) begin
            words[14] <= bit_len[31:0];
            words[15] <= bit_len[63:32];
            act   <= ACT_FINAL;
            state <= S_CLOAD;
          end else if (pad_pos == mdd_pkg::BLK_END) begin
            pad_pos <= '0;
            act     <= ACT_PADZ;
            state   <= S_CLOAD;
          end else begin
            if (wr_pos[1:0] == 2'd0) begin
              words[wr_pos[5:2]] <= '0;
            end
            pad_pos <= pad_pos + 7'd1;
          end
        end
        S_CLOAD: begin
          wa    <= chain_a;
          wb    <= chain_b;
          wc    <= chain_c;
          wd    <= chain_d;
          round <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          wa    <= wd;
          wd    <= wc;
          wc    <= wb;
          wb    <= wb + tt[63:32];
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_CADD;
          end
        end
        S_CADD: begin
          case (act)
            ACT_FINAL: begin
              if (!out_valid || pop) begin
                result     <= '{sum_a, sum_b, sum_c, sum_d};
                out_valid  <= 1'b1;
                chain_a    <= mdd_pkg::INIT_A;
                chain_b    <= mdd_pkg::INIT_B;
                chain_c    <= mdd_pkg::INIT_C;
                chain_d    <= mdd_pkg::INIT_D;
                byte_total <= '0;
                state      <= S_IDLE;
              end
            end
            ACT_PAD0: begin
              chain_a <= sum_a; chain_b <= sum_b; chain_c <= sum_c; chain_d <= sum_d;
              state   <= S_PAD0;
            end
            ACT_PADZ: begin
              chain_a <= sum_a; chain_b <= sum_b; chain_c <= sum_c; chain_d <= sum_d;
              state   <= S_PADZ;
            end
            default: begin
              chain_a <= sum_a; chain_b <= sum_b; chain_c <= sum_c; chain_d <= sum_d;
              state   <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/md5_message_digest.sv
// top level of the md5 message digest block: input queue and compression engine
// depends on mdd_pkg, mdd_front, mdd_back
//
//   channel   handshake       payload                  moves
//   input     push / full     data   (mdd_pkg::in_item_t)   one message byte or end mark
//   result    pop / empty     result (mdd_pkg::out_item_t)  one digest per message
//
// each byte is packed into the message words; every 64th byte starts a compression
// (load, 64 rounds one per cycle through the single round unit, chaining add)
// the end of a message writes the pad marker, then the zero fill and the bit length,
// and runs one or two compressions before the digest appears
// synchronous reset empties the queue, resets the engine state and reloads the initial chaining words
// the queue keeps taking transactions while the engine compresses; a digest not
// yet popped only holds the engine at the end of the next message
module md5_message_digest #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mdd_pkg::in_item_t  data,
  output logic               empty,
  input  logic               pop,
  output mdd_pkg::out_item_t result
);
  // queue head as seen by the engine
  mdd_pkg::q_head_t    head;
  logic                q_pop;
  // engine status for the checks below
  mdd_pkg::bk_status_t status;

  mdd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .data (data),
    .head (head),
    .q_pop(q_pop)
  );

  mdd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .q_pop (q_pop),
    .empty (empty),
    .pop   (pop),
    .result(result),
    .status(status)
  );

  // round counter only moves while rounds are running
  a_round_idle: assert property (@(posedge clk) disable iff (rst)
    !status.compressing |-> status.round == 6'd0 || $past(status.compressing))
    else $error("round counter left non-zero outside compression");

  // a digest only appears after the final chaining add
  a_digest_src: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(status.finishing))
    else $error("digest raised without a final compression");

  // an accepted transaction is visible to the engine next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> head.valid)
    else $error("accepted transaction missing from queue");

  // engine never takes a queued byte while rounds are running
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    status.compressing |-> !q_pop)
    else $error("queue popped during compression");
endmodule
